[design/rarp_pkg.sv]
// Shared types and constants of the RAR MAC PDU parser.
`timescale 1ns / 1ps

package rarp_pkg;

  localparam int BYTE_W     = 8;
  localparam int OWN_PRE_W  = 6;
  localparam int SI_CNT_W   = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int RAR_LEN    = 7;
  localparam int BUF_DEPTH  = RAR_LEN - 1;
  localparam int POS_W      = 3;
  localparam int SKIP_W     = 3;

  localparam logic [SI_CNT_W-1:0] SI_CNT_RESET = 7'd16;
  localparam logic [SKIP_W-1:0]   RAR_SKIP     = 3'd7;
  localparam logic [POS_W-1:0]    POS_LAST     = 3'(RAR_LEN - 1);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_PREAMBLE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SI_COUNT     = 1'd1;

  typedef enum logic [1:0] {
    ST_RAR_FOUND = 2'd0,
    ST_SI_ACK    = 2'd1,
    ST_NO_MATCH  = 2'd2,
    ST_TRUNCATED = 2'd3
  } rarp_status_t;

  typedef struct packed {
    logic [OWN_PRE_W-1:0] own_preamble;
    logic [SI_CNT_W-1:0]  si_preamble_count;
  } rarp_cfg_t;

  typedef struct packed {
    rarp_status_t status;
    logic         backoff_seen;
    logic [3:0]   backoff_ind;
    logic [11:0]  timing_advance;
    logic         hop_flag;
    logic [13:0]  freq_alloc;
    logic [3:0]   time_alloc;
    logic [3:0]   mcs;
    logic [2:0]   tpc;
    logic         csi_req;
    logic [15:0]  temp_rnti;
  } rarp_result_t;

endpackage

[design/rarp_if.sv]
// Valid/ready channel interfaces: octet input, result output, register write.
`timescale 1ns / 1ps

interface rarp_in_if import rarp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              pdu_last;

  modport source (output valid, output rx_byte, output pdu_last, input ready);
  modport sink   (input valid, input rx_byte, input pdu_last, output ready);
endinterface

interface rarp_out_if import rarp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        backoff_seen;
  logic [3:0]  backoff_ind;
  logic [11:0] timing_advance;
  logic        hop_flag;
  logic [13:0] freq_alloc;
  logic [3:0]  time_alloc;
  logic [3:0]  mcs;
  logic [2:0]  tpc;
  logic        csi_req;
  logic [15:0] temp_rnti;

  modport source (output valid, output status, output backoff_seen, output backoff_ind,
                  output timing_advance, output hop_flag, output freq_alloc,
                  output time_alloc, output mcs, output tpc, output csi_req,
                  output temp_rnti, input ready);
  modport sink   (input valid, input status, input backoff_seen, input backoff_ind,
                  input timing_advance, input hop_flag, input freq_alloc,
                  input time_alloc, input mcs, input tpc, input csi_req,
                  input temp_rnti, output ready);
endinterface

interface rarp_cfg_if import rarp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

[design/nr_rar_pdu_parser.sv]
// Top level of the NR random access response MAC PDU parser.
`timescale 1ns / 1ps

// Usage:
//   in_if   : one octet of a RAR MAC PDU per word, pdu_last set on the final
//             octet. Octets of a PDU arrive in order.
//   out_if  : at most one result word per PDU (rar_found, si_ack, no_match or
//             truncated) with the backoff indicator and, for rar_found, the
//             unpacked UL grant, timing advance and temporary C-RNTI.
//   cfg_if  : register writes, addr 0 own_preamble, addr 1 si_preamble_count.
//             Always ready; write only while no PDU is in flight.
// Throughput: one octet per cycle unless stalled. The parse state updates in
//   the accepting cycle and a result lands in the output register at that same
//   edge, so out_if.valid rises in the cycle after the completing octet.
// Stall: in_if.ready drops only while the output register holds a word that
//   the receiver does not take this cycle; with out_if.ready high the block
//   streams an octet every cycle.
// Reset: synchronous, active low. Clears the parse state, empties the output
//   register and restores own_preamble to 0 and si_preamble_count to 16.
//   The RAR capture buffer has no reset; it is always written before use.

module nr_rar_pdu_parser import rarp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rarp_in_if.sink   in_if,
  rarp_out_if.source out_if,
  rarp_cfg_if.sink  cfg_if
);

  rarp_cfg_t    cfg_r;
  logic         in_acc;
  logic         core_valid;
  rarp_result_t core_res;
  logic         out_valid_r, out_valid_nxt;
  rarp_result_t out_res_r;

  // Configuration registers; drop writes to unknown addresses.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_preamble      <= '0;
      cfg_r.si_preamble_count <= SI_CNT_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.addr)
        CFG_OWN_PREAMBLE: cfg_r.own_preamble      <= cfg_if.data[OWN_PRE_W-1:0];
        CFG_SI_COUNT:     cfg_r.si_preamble_count <= cfg_if.data[SI_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take an octet whenever the output register is free or being drained.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  rarp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .en       (in_acc),
    .rx_byte  (in_if.rx_byte),
    .pdu_last (in_if.pdu_last),
    .res_valid(core_valid),
    .res      (core_res)
  );

  // Output register: load a fresh result, clear when taken, hold otherwise.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && core_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_res_r.status;
  assign out_if.backoff_seen   = out_res_r.backoff_seen;
  assign out_if.backoff_ind    = out_res_r.backoff_ind;
  assign out_if.timing_advance = out_res_r.timing_advance;
  assign out_if.hop_flag       = out_res_r.hop_flag;
  assign out_if.freq_alloc     = out_res_r.freq_alloc;
  assign out_if.time_alloc     = out_res_r.time_alloc;
  assign out_if.mcs            = out_res_r.mcs;
  assign out_if.tpc            = out_res_r.tpc;
  assign out_if.csi_req        = out_res_r.csi_req;
  assign out_if.temp_rnti      = out_res_r.temp_rnti;

endmodule

[design/rarp_core.sv]
// Per-octet parse state machine: subheader decode, skip, RAR capture and unpack.
`timescale 1ns / 1ps

module rarp_core import rarp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  rarp_cfg_t         cfg,
  input  logic              en,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              pdu_last,
  output logic              res_valid,
  output rarp_result_t      res
);

  typedef enum logic [3:0] {
    PH_EXPECT  = 4'b0001,
    PH_SKIP    = 4'b0010,
    PH_CAPTURE = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              first_r, first_nxt;
  logic [3:0]        bi_r, bi_nxt;
  logic              bi_seen_r, bi_seen_nxt;
  logic [BYTE_W-1:0] cap_buf_r [BUF_DEPTH];

  logic [OWN_PRE_W-1:0] rapid;
  logic                 rapid_le_si;
  logic                 with_rar;

  assign rapid       = rx_byte[OWN_PRE_W-1:0];
  assign rapid_le_si = {1'b0, rapid} <= cfg.si_preamble_count;

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    pos_nxt     = pos_r;
    first_nxt   = 1'b0;
    bi_nxt      = bi_r;
    bi_seen_nxt = bi_seen_r;
    res_valid   = 1'b0;
    with_rar    = 1'b0;
    res         = '0;

    unique case (phase_r)
      PH_EXPECT: begin
        if (!rx_byte[6]) begin
          // Backoff subheader counts only as the opening octet.
          if (first_r) begin
            bi_nxt      = rx_byte[3:0];
            bi_seen_nxt = 1'b1;
          end
        end else if (rapid == cfg.own_preamble) begin
          if (rapid_le_si) begin
            res_valid  = 1'b1;
            res.status = ST_SI_ACK;
            phase_nxt  = PH_DONE;
          end else begin
            phase_nxt = PH_CAPTURE;
            pos_nxt   = '0;
          end
        end else if (!rapid_le_si) begin
          skip_nxt  = RAR_SKIP;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 1'b1;
        if (skip_r == SKIP_W'(1)) begin
          phase_nxt = PH_EXPECT;
        end
      end
      PH_CAPTURE: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == POS_LAST) begin
          res_valid  = 1'b1;
          with_rar   = 1'b1;
          res.status = ST_RAR_FOUND;
          phase_nxt  = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_EXPECT;
      end
    endcase

    // Close the PDU: report no match or truncation if nothing was given yet.
    if (pdu_last && phase_nxt != PH_DONE) begin
      res_valid  = 1'b1;
      res.status = (phase_nxt == PH_CAPTURE) ? ST_TRUNCATED : ST_NO_MATCH;
    end

    res.backoff_seen = bi_seen_nxt;
    res.backoff_ind  = bi_nxt;

    // Unpack the MAC RAR; the seventh octet is the one on the input now.
    if (with_rar) begin
      res.timing_advance = {cap_buf_r[0][6:0], cap_buf_r[1][7:3]};
      res.hop_flag       = cap_buf_r[1][2];
      res.freq_alloc     = {cap_buf_r[1][1:0], cap_buf_r[2], cap_buf_r[3][7:4]};
      res.time_alloc     = cap_buf_r[3][3:0];
      res.mcs            = cap_buf_r[4][7:4];
      res.tpc            = cap_buf_r[4][3:1];
      res.csi_req        = cap_buf_r[4][0];
      res.temp_rnti      = {cap_buf_r[5], rx_byte};
    end

    if (pdu_last) begin
      phase_nxt   = PH_EXPECT;
      skip_nxt    = '0;
      pos_nxt     = '0;
      first_nxt   = 1'b1;
      bi_nxt      = '0;
      bi_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_EXPECT;
      skip_r    <= '0;
      pos_r     <= '0;
      first_r   <= 1'b1;
      bi_r      <= '0;
      bi_seen_r <= 1'b0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      pos_r     <= pos_nxt;
      first_r   <= first_nxt;
      bi_r      <= bi_nxt;
      bi_seen_r <= bi_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && phase_r == PH_CAPTURE && pos_r != POS_LAST) begin
      cap_buf_r[pos_r] <= rx_byte;
    end
  end

endmodule

[design/rarp_checker.sv]
// Port-level assertions for the RAR parser, bound to its top level.
`timescale 1ns / 1ps

module rarp_checker import rarp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        backoff_seen,
  input logic [3:0]  backoff_ind,
  input logic [11:0] timing_advance,
  input logic [13:0] freq_alloc,
  input logic [15:0] temp_rnti
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(temp_rnti))
    else $error("result word changed while stalled");

  a_ready_only_blocked_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free output register");

  a_result_from_octet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result word without an accepted octet");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_RAR_FOUND |->
      timing_advance == '0 && freq_alloc == '0 && temp_rnti == '0)
    else $error("grant fields set on a result without a RAR");

  a_backoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !backoff_seen |-> backoff_ind == '0)
    else $error("backoff indicator set without a backoff subheader");

endmodule

bind nr_rar_pdu_parser rarp_checker u_rarp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .status        (out_if.status),
  .backoff_seen  (out_if.backoff_seen),
  .backoff_ind   (out_if.backoff_ind),
  .timing_advance(out_if.timing_advance),
  .freq_alloc    (out_if.freq_alloc),
  .temp_rnti     (out_if.temp_rnti)
);

[dv/nr_rar_pdu_parser_test.sv]
// Self-checking testbench for the RAR MAC PDU parser: octet stream in, result words out.
`timescale 1ns / 1ps

module nr_rar_pdu_parser_test;
  import rarp_pkg::*;

  // Run bounds.
  localparam int CYCLE_LIMIT   = 250000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_OCTETS  = 250;
  localparam int NUM_SETTINGS  = 6;
  localparam int HOLD_AT_OCTET = 600;
  localparam int HOLD_CYCLES   = 300;

  // Register settings of the random phases; the last one is drawn at random.
  // The raw data carries spare high bits so the register masking gets exercised.
  localparam logic [7:0] OWN_DATA [NUM_SETTINGS] = '{8'hd1, 8'hff, 8'h00, 8'h50, 8'h28, 8'h00};
  localparam logic [7:0] SI_DATA  [NUM_SETTINGS] = '{8'h10, 8'hff, 8'h00, 8'h90, 8'h40, 8'h00};

  typedef enum logic [1:0] {PH_HUNT, PH_SKIP, PH_CAPTURE, PH_DONE} parse_phase_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
  } octet_word_t;

  // Clock, reset and every block input start at known values.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic                  in_last   = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rarp_in_if  in_if ();
  rarp_out_if out_if ();
  rarp_cfg_if cfg_if ();

  assign in_if.valid    = in_valid;
  assign in_if.rx_byte  = in_byte;
  assign in_if.pdu_last = in_last;
  assign out_if.ready   = out_ready;
  assign cfg_if.valid   = cfg_valid;
  assign cfg_if.addr    = cfg_addr;
  assign cfg_if.data    = cfg_data;

  nr_rar_pdu_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser shadow: register copies, parse state and the reports it predicts.
  // ---------------------------------------------------------------------------
  logic [5:0]   own_pre;
  logic [6:0]   si_cnt;
  parse_phase_t ph;
  logic [2:0]   skip_cnt;
  logic [7:0]   rar_buf [RAR_LEN];
  logic [2:0]   rar_pos;
  logic         first_octet;
  logic [3:0]   bi_val;
  logic         bi_seen;
  logic         reported;

  rarp_result_t reports_due [$];

  // Bookkeeping.
  octet_word_t octet_feed [$];
  logic [7:0]  pdu_buf [$];
  int          octets_queued = 0;
  int          pdus_queued   = 0;
  int          octets_in     = 0;
  int          fail_cnt      = 0;
  int          cycle_cnt     = 0;
  int          status_seen [4] = '{0, 0, 0, 0};

  // Return to the start-of-PDU state; registers are untouched.
  function automatic void clear_parse();
    ph          = PH_HUNT;
    skip_cnt    = '0;
    rar_pos     = '0;
    first_octet = 1'b1;
    bi_val      = '0;
    bi_seen     = 1'b0;
    reported    = 1'b0;
  endfunction

  // Queue the one report of the current PDU; grant fields only for a found RAR.
  function automatic void queue_report(rarp_status_t st, bit with_rar);
    rarp_result_t r;
    r              = '0;
    r.status       = st;
    r.backoff_seen = bi_seen;
    r.backoff_ind  = bi_val;
    if (with_rar) begin
      r.timing_advance = {rar_buf[0][6:0], rar_buf[1][7:3]};
      r.hop_flag       = rar_buf[1][2];
      r.freq_alloc     = {rar_buf[1][1:0], rar_buf[2], rar_buf[3][7:4]};
      r.time_alloc     = rar_buf[3][3:0];
      r.mcs            = rar_buf[4][7:4];
      r.tpc            = rar_buf[4][3:1];
      r.csi_req        = rar_buf[4][0];
      r.temp_rnti      = {rar_buf[5], rar_buf[6]};
    end
    reports_due.push_back(r);
    reported = 1'b1;
  endfunction

  // Advance the shadow parser by one accepted octet.
  function automatic void parse_octet(logic [7:0] b, logic lst);
    logic       was_first;
    logic [5:0] rapid;
    was_first   = first_octet;
    first_octet = 1'b0;
    rapid       = b[5:0];
    case (ph)
      PH_HUNT: begin
        if (!b[6]) begin
          // Backoff subheader counts only as the opening octet; later ones are skipped.
          if (was_first) begin
            bi_val  = b[3:0];
            bi_seen = 1'b1;
          end
        end else if (rapid == own_pre) begin
          if ({1'b0, rapid} <= si_cnt) begin
            queue_report(ST_SI_ACK, 1'b0);
            ph = PH_DONE;
          end else begin
            ph      = PH_CAPTURE;
            rar_pos = '0;
          end
        end else if ({1'b0, rapid} > si_cnt) begin
          // Foreign RAPID with a MAC RAR behind it: drop the 7 RAR octets.
          skip_cnt = RAR_SKIP;
          ph       = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 3'd1;
        if (skip_cnt == '0) ph = PH_HUNT;
      end
      PH_CAPTURE: begin
        rar_buf[rar_pos] = b;
        rar_pos          = rar_pos + 3'd1;
        if (rar_pos == 3'(RAR_LEN)) begin
          queue_report(ST_RAR_FOUND, 1'b1);
          ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (lst) begin
      if (!reported) begin
        if (ph == PH_CAPTURE) queue_report(ST_TRUNCATED, 1'b0);
        else queue_report(ST_NO_MATCH, 1'b0);
      end
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // PDU builders: assemble octets in pdu_buf, then hand them to the driver.
  // ---------------------------------------------------------------------------
  function automatic void flush_pdu();
    octet_word_t w;
    foreach (pdu_buf[i]) begin
      w.octet = pdu_buf[i];
      w.last  = (i == pdu_buf.size() - 1);
      octet_feed.push_back(w);
    end
    octets_queued += pdu_buf.size();
    pdus_queued++;
    pdu_buf.delete();
  endfunction

  // Append one MAC RAR body; sometimes all zeros or all ones for field extremes.
  function automatic void add_rar_body();
    int fill;
    fill = $urandom_range(0, 7);
    repeat (RAR_LEN) begin
      if (fill == 0) pdu_buf.push_back(8'h00);
      else if (fill == 1) pdu_buf.push_back(8'hff);
      else pdu_buf.push_back(8'($urandom));
    end
  endfunction

  // Mostly well-formed PDUs with random content, mixed with noise and truncation.
  function automatic void build_random_pdu();
    int         n_sub;
    int         kind;
    int         cut;
    logic [5:0] rapid;
    pdu_buf.delete();
    if ($urandom_range(0, 2) == 0) pdu_buf.push_back(8'($urandom) & 8'hbf);
    n_sub = $urandom_range(0, 4);
    for (int i = 0; i < n_sub; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          // Our own RAPID: SI acknowledge or a RAR to capture.
          pdu_buf.push_back({1'($urandom), 1'b1, own_pre});
          if ({1'b0, own_pre} > si_cnt) add_rar_body();
        end
        4, 5: begin
          if (int'(si_cnt) < 63) rapid = 6'($urandom_range(int'(si_cnt) + 1, 63));
          else rapid = 6'($urandom);
          pdu_buf.push_back({1'($urandom), 1'b1, rapid});
          add_rar_body();
        end
        6: begin
          rapid = 6'($urandom_range(0, (int'(si_cnt) > 63) ? 63 : int'(si_cnt)));
          pdu_buf.push_back({1'($urandom), 1'b1, rapid});
        end
        7: pdu_buf.push_back(8'($urandom) & 8'hbf);
        default: pdu_buf.push_back(8'($urandom));
      endcase
    end
    repeat ($urandom_range(0, 2)) pdu_buf.push_back(8'($urandom));
    if (pdu_buf.size() == 0) pdu_buf.push_back(8'($urandom));
    // Cut some PDUs short so captures and skips end on the last octet.
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, pdu_buf.size());
      while (pdu_buf.size() > cut) void'(pdu_buf.pop_back());
    end
    flush_pdu();
  endfunction

  // ---------------------------------------------------------------------------
  // Octet driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_octets
    octet_word_t w;
    if (rst_n) begin
      // Predict on acceptance, using the word that stood on the bus.
      if (in_valid && in_if.ready) begin
        parse_octet(in_byte, in_last);
        octets_in++;
      end
      // Advance only when the bus is free or its word was just taken.
      if (!in_valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (octet_feed.size() != 0) begin
          w = octet_feed.pop_front();
          in_valid <= 1'b1;
          in_byte  <= w.octet;
          in_last  <= w.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: segments of always-ready, coin-flip, starved and periodic
  // acceptance, plus one long hold that backs the parser up into its input.
  // ---------------------------------------------------------------------------
  int rx_mode   = 0;
  int seg_left  = 0;
  int rx_tick   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : drive_result_ready
    if (rst_n) begin
      if (!hold_done && octets_in >= HOLD_AT_OCTET) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 160);
        end
        seg_left--;
        rx_tick++;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 5) == 0);
          default: out_ready <= ((rx_tick % 5) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted word against the oldest predicted report.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    rarp_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("status: expected no result word, got 0x%0h", out_if.status);
        fail_cnt++;
      end else begin
        want = reports_due.pop_front();
        check_field("status", 16'(want.status), 16'(out_if.status));
        check_field("backoff_seen", 16'(want.backoff_seen), 16'(out_if.backoff_seen));
        check_field("backoff_ind", 16'(want.backoff_ind), 16'(out_if.backoff_ind));
        check_field("timing_advance", 16'(want.timing_advance),
                    16'(out_if.timing_advance));
        check_field("hop_flag", 16'(want.hop_flag), 16'(out_if.hop_flag));
        check_field("freq_alloc", 16'(want.freq_alloc), 16'(out_if.freq_alloc));
        check_field("time_alloc", 16'(want.time_alloc), 16'(out_if.time_alloc));
        check_field("mcs", 16'(want.mcs), 16'(out_if.mcs));
        check_field("tpc", 16'(want.tpc), 16'(out_if.tpc));
        check_field("csi_req", 16'(want.csi_req), 16'(out_if.csi_req));
        check_field("temp_rnti", want.temp_rnti, out_if.temp_rnti);
        status_seen[want.status]++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Register writes and idle waits, used from the stimulus sequence.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_OWN_PREAMBLE) own_pre = value[5:0];
    else si_cnt = value[6:0];
    cfg_valid <= 1'b0;
  endtask

  // Hold until every octet is taken and every report has come back, then let
  // the pipeline run dry.
  task automatic settle();
    while (octet_feed.size() != 0 || in_valid || reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] own_data;
    logic [7:0] si_data;
    own_pre = '0;
    si_cnt  = SI_CNT_RESET;
    clear_parse();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values (own preamble 0, SI count 16).
    // Backoff with full indicator, own RAPID in the SI range, then an ignored octet.
    pdu_buf = {8'h3f, 8'h40, 8'hff};
    flush_pdu();
    // One-octet PDU: backoff only, ends without a match.
    pdu_buf = {8'h80};
    flush_pdu();
    settle();

    // Directed, own preamble 63 and SI count 0.
    write_reg(CFG_OWN_PREAMBLE, 8'hff);
    write_reg(CFG_SI_COUNT, 8'h00);
    // RAR of all ones, completed by the last octet.
    pdu_buf = {8'h7f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    flush_pdu();
    // Foreign SI RAPID (skip one), late backoff (skip one), foreign RAPID with
    // a zero RAR (skip eight), then our RAPID whose RAR is cut short.
    pdu_buf = {8'h40, 8'h00, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'hff, 8'h12, 8'h34};
    flush_pdu();
    settle();

    // Random phases, one register setting each.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      own_data = (p == NUM_SETTINGS - 1) ? 8'($urandom) : OWN_DATA[p];
      si_data  = (p == NUM_SETTINGS - 1) ? 8'($urandom) : SI_DATA[p];
      write_reg(CFG_OWN_PREAMBLE, own_data);
      write_reg(CFG_SI_COUNT, si_data);
      octets_queued = 0;
      while (octets_queued < PHASE_OCTETS) build_random_pdu();
      settle();
    end

    $display("Run covered %0d octets in %0d PDUs across %0d register settings, %0d-cycle hold.",
             octets_in, pdus_queued, NUM_SETTINGS + 2, HOLD_CYCLES);
    $display("Reports: %0d rar_found, %0d si_ack, %0d no_match, %0d truncated.",
             status_seen[ST_RAR_FOUND], status_seen[ST_SI_ACK],
             status_seen[ST_NO_MATCH], status_seen[ST_TRUNCATED]);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/rarp_pkg.sv
design/rarp_if.sv
design/rarp_core.sv
design/nr_rar_pdu_parser.sv
design/rarp_checker.sv
dv/nr_rar_pdu_parser_test.sv
